>>> rtl/tstu_pkg.sv
// Shared types and constants for the tank schedule and thermostat unit.
package tstu_pkg;

    typedef struct packed {
        logic [4:0]         clock_hour;
        logic [5:0]         clock_minute;
        logic [5:0]         clock_second;
        logic signed [15:0] water_temp;
        logic               sensor_present;
        logic               menu_active;
    } tstu_item_t;

    typedef struct packed {
        logic [4:0] cycle_hours;
        logic [7:0] duration;
    } tstu_run_cfg_t;

    typedef struct packed {
        logic [7:0] temp_setpoint;
        logic [4:0] light_on_hour;
        logic [4:0] light_off_hour;
    } tstu_clim_cfg_t;

    typedef enum logic [2:0] {
        REG_TEMP_SETPOINT     = 3'd0,
        REG_LIGHT_ON_HOUR     = 3'd1,
        REG_LIGHT_OFF_HOUR    = 3'd2,
        REG_FEED_CYCLE_HOURS  = 3'd3,
        REG_FEED_DURATION_SEC = 3'd4,
        REG_AIR_CYCLE_HOURS   = 3'd5,
        REG_AIR_DURATION_MIN  = 3'd6
    } tstu_reg_index_t;

    localparam logic signed [15:0] TEMP_LIMIT_16THS = 16'sd2400;
    localparam logic [7:0]  SETPOINT_UNSET      = 8'd255;
    localparam logic [7:0]  SETPOINT_DEFAULT    = 8'd25;
    localparam logic [4:0]  BACKLIGHT_DAY_START = 5'd8;
    localparam logic [4:0]  BACKLIGHT_DAY_END   = 5'd17;
    localparam logic [6:0]  HOURS_PER_DAY       = 7'd24;
    localparam logic [16:0] SEC_PER_HOUR        = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN         = 17'd60;
    localparam logic [10:0] MIN_PER_HOUR        = 11'd60;
    localparam logic [16:0] SEC_PER_DAY         = 17'd86400;
    localparam logic [16:0] MIN_PER_DAY         = 17'd1440;

    localparam logic [7:0]  RST_TEMP_SETPOINT     = 8'd25;
    localparam logic [4:0]  RST_LIGHT_ON_HOUR     = 5'd8;
    localparam logic [4:0]  RST_LIGHT_OFF_HOUR    = 5'd20;
    localparam logic [4:0]  RST_FEED_CYCLE_HOURS  = 5'd0;
    localparam logic [7:0]  RST_FEED_DURATION_SEC = 8'd5;
    localparam logic [4:0]  RST_AIR_CYCLE_HOURS   = 5'd0;
    localparam logic [7:0]  RST_AIR_DURATION_MIN  = 8'd10;

endpackage

>>> rtl/tstu_climate.sv
// Heater thermostat, light window and backlight schedule state.
module tstu_climate (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick,
    input  tstu_pkg::tstu_item_t  item,
    input  tstu_pkg::tstu_clim_cfg_t cfg,
    output logic                  heater_on,
    output logic                  light_on,
    output logic                  backlight_on
);
    import tstu_pkg::*;

    logic               heater_reg, heater_next;
    logic               light_reg, light_next;
    logic               backlight_reg, backlight_next;
    logic [7:0]         setpoint;
    logic signed [15:0] setpoint16;

    assign setpoint   = (cfg.temp_setpoint == SETPOINT_UNSET) ? SETPOINT_DEFAULT
                                                               : cfg.temp_setpoint;
    assign setpoint16 = signed'({4'b0000, setpoint, 4'b0000});

    always_comb begin
        heater_next    = heater_reg;
        light_next     = light_reg;
        backlight_next = backlight_reg;
        if (tick) begin
            if (item.menu_active) begin
                backlight_next = 1'b1;
            end else begin
                backlight_next = (item.clock_hour > BACKLIGHT_DAY_END) ||
                                 (item.clock_hour < BACKLIGHT_DAY_START);
                if (item.sensor_present && (item.water_temp < TEMP_LIMIT_16THS)) begin
                    if (setpoint16 > item.water_temp) begin
                        heater_next = 1'b1;
                    end else if (setpoint16 < item.water_temp) begin
                        heater_next = 1'b0;
                    end
                end else begin
                    heater_next = 1'b0;
                end
                if (cfg.light_on_hour < cfg.light_off_hour) begin
                    light_next = (item.clock_hour >= cfg.light_on_hour) &&
                                 (item.clock_hour < cfg.light_off_hour);
                end else if (cfg.light_on_hour > cfg.light_off_hour) begin
                    light_next = (item.clock_hour >= cfg.light_on_hour) ||
                                 (item.clock_hour < cfg.light_off_hour);
                end else begin
                    light_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heater_reg    <= 1'b1;
            light_reg     <= 1'b1;
            backlight_reg <= 1'b1;
        end else begin
            heater_reg    <= heater_next;
            light_reg     <= light_next;
            backlight_reg <= backlight_next;
        end
    end

    assign heater_on    = heater_reg;
    assign light_on     = light_reg;
    assign backlight_on = backlight_reg;

endmodule

>>> rtl/tstu_runner.sv
// Periodic run timer shared by the feeder and the air pump.
module tstu_runner (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    tick,
    input  logic [4:0]              hour,
    input  logic [16:0]             now,
    input  logic [16:0]             day_len,
    input  tstu_pkg::tstu_run_cfg_t cfg,
    output logic                    running
);
    import tstu_pkg::*;

    logic        running_reg, running_next;
    logic [16:0] start_reg, start_next;
    logic [4:0]  last_hour_reg, last_hour_next;
    logic [6:0]  hdiff_raw;
    logic [4:0]  hdiff;
    logic        due;
    logic [18:0] day2, day3, span, span_mod;
    logic [16:0] elapsed;

    assign hdiff_raw = 7'(hour) + (HOURS_PER_DAY << 1) - 7'(last_hour_reg);

    always_comb begin
        priority if (hdiff_raw >= 7'(3 * HOURS_PER_DAY)) begin
            hdiff = 5'(hdiff_raw - 7'(3 * HOURS_PER_DAY));
        end else if (hdiff_raw >= (HOURS_PER_DAY << 1)) begin
            hdiff = 5'(hdiff_raw - (HOURS_PER_DAY << 1));
        end else if (hdiff_raw >= HOURS_PER_DAY) begin
            hdiff = 5'(hdiff_raw - HOURS_PER_DAY);
        end else begin
            hdiff = 5'(hdiff_raw);
        end
    end

    assign due  = (cfg.cycle_hours != 5'd0) && (hdiff >= cfg.cycle_hours);
    assign day2 = {1'b0, day_len, 1'b0};
    assign day3 = day2 + 19'(day_len);
    assign span = 19'(now) + day2 - 19'(start_reg);

    always_comb begin
        priority if (span >= day3) begin
            span_mod = span - day3;
        end else if (span >= day2) begin
            span_mod = span - day2;
        end else if (span >= 19'(day_len)) begin
            span_mod = span - 19'(day_len);
        end else begin
            span_mod = span;
        end
    end

    assign elapsed = span_mod[16:0];

    always_comb begin
        running_next   = running_reg;
        start_next     = start_reg;
        last_hour_next = last_hour_reg;
        if (tick && due) begin
            if (!running_reg) begin
                running_next = 1'b1;
                start_next   = now;
            end else if (17'(cfg.duration) < elapsed) begin
                running_next   = 1'b0;
                last_hour_next = hour;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            start_reg     <= '0;
            last_hour_reg <= '0;
        end else begin
            running_reg   <= running_next;
            start_reg     <= start_next;
            last_hour_reg <= last_hour_next;
        end
    end

    assign running = running_reg;

endmodule

>>> rtl/tank_schedule_and_thermostat_unit.sv
// Top level of the tank schedule and thermostat unit.
//
//  channel   | ports                          | direction
//  ----------+--------------------------------+----------
//  s_        | s_valid/s_ready, six fields    | in
//  m_        | m_valid/m_ready, five drives   | out
//  cfg_      | cfg_valid/cfg_ready, index,data| in
//
// One transaction per clock is sustained while m_ready stays high; a taken input waits
// in the input register before the state update, which registers its result.
// The state registers themselves form the result register.
// Reset is synchronous; every register but the input register is reset.
// A stalled result holds the input register; the next transaction is taken in the
// same cycle the waiting result leaves.
module tank_schedule_and_thermostat_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_clock_hour,
    input  logic [5:0]         s_clock_minute,
    input  logic [5:0]         s_clock_second,
    input  logic signed [15:0] s_water_temp,
    input  logic               s_sensor_present,
    input  logic               s_menu_active,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_heater_on,
    output logic               m_light_on,
    output logic               m_feeder_on,
    output logic               m_air_on,
    output logic               m_backlight_on,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import tstu_pkg::*;

    tstu_item_t     item_reg;
    logic           in_valid_reg, in_valid_next;
    logic           m_valid_reg, m_valid_next;
    logic           advance;
    logic           run_tick;
    tstu_clim_cfg_t clim_cfg_reg;
    tstu_run_cfg_t  feed_cfg_reg;
    tstu_run_cfg_t  air_cfg_reg;
    logic [16:0]    feed_now;
    logic [10:0]    air_now;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign run_tick  = advance && !item_reg.menu_active;

    always_comb begin
        in_valid_next = in_valid_reg;
        m_valid_next  = m_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.clock_hour     <= s_clock_hour;
            item_reg.clock_minute   <= s_clock_minute;
            item_reg.clock_second   <= s_clock_second;
            item_reg.water_temp     <= s_water_temp;
            item_reg.sensor_present <= s_sensor_present;
            item_reg.menu_active    <= s_menu_active;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clim_cfg_reg.temp_setpoint  <= RST_TEMP_SETPOINT;
            clim_cfg_reg.light_on_hour  <= RST_LIGHT_ON_HOUR;
            clim_cfg_reg.light_off_hour <= RST_LIGHT_OFF_HOUR;
            feed_cfg_reg.cycle_hours    <= RST_FEED_CYCLE_HOURS;
            feed_cfg_reg.duration       <= RST_FEED_DURATION_SEC;
            air_cfg_reg.cycle_hours     <= RST_AIR_CYCLE_HOURS;
            air_cfg_reg.duration        <= RST_AIR_DURATION_MIN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TEMP_SETPOINT:     clim_cfg_reg.temp_setpoint  <= cfg_data;
                REG_LIGHT_ON_HOUR:     clim_cfg_reg.light_on_hour  <= cfg_data[4:0];
                REG_LIGHT_OFF_HOUR:    clim_cfg_reg.light_off_hour <= cfg_data[4:0];
                REG_FEED_CYCLE_HOURS:  feed_cfg_reg.cycle_hours    <= cfg_data[4:0];
                REG_FEED_DURATION_SEC: feed_cfg_reg.duration       <= cfg_data;
                REG_AIR_CYCLE_HOURS:   air_cfg_reg.cycle_hours     <= cfg_data[4:0];
                REG_AIR_DURATION_MIN:  air_cfg_reg.duration        <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign feed_now = 17'(item_reg.clock_hour) * SEC_PER_HOUR +
                      17'(item_reg.clock_minute) * SEC_PER_MIN +
                      17'(item_reg.clock_second);
    assign air_now  = 11'(item_reg.clock_hour) * MIN_PER_HOUR +
                      11'(item_reg.clock_minute);

    tstu_climate u_climate (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (advance),
        .item         (item_reg),
        .cfg          (clim_cfg_reg),
        .heater_on    (m_heater_on),
        .light_on     (m_light_on),
        .backlight_on (m_backlight_on)
    );

    tstu_runner u_feed (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (run_tick),
        .hour    (item_reg.clock_hour),
        .now     (feed_now),
        .day_len (SEC_PER_DAY),
        .cfg     (feed_cfg_reg),
        .running (m_feeder_on)
    );

    tstu_runner u_air (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (run_tick),
        .hour    (item_reg.clock_hour),
        .now     (17'(air_now)),
        .day_len (MIN_PER_DAY),
        .cfg     (air_cfg_reg),
        .running (m_air_on)
    );

    assign m_valid = m_valid_reg;

    a_menu_holds_heater: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.menu_active |=> m_heater_on == $past(m_heater_on))
        else $error("heater changed on a menu transaction");

    a_menu_backlight: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.menu_active |=> m_backlight_on)
        else $error("backlight not forced on by menu transaction");

    a_no_sensor_heater_off: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item_reg.menu_active && !item_reg.sensor_present |=> !m_heater_on)
        else $error("heater on without a sensor");

    a_feed_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        feed_cfg_reg.cycle_hours == 5'd0 && !m_feeder_on |=> !m_feeder_on)
        else $error("feeder started while disabled");

    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance))
        else $error("result valid without a transaction");

endmodule

>>> tb/tank_schedule_and_thermostat_unit_tb.sv
// Self-checking testbench for the tank schedule and thermostat unit: directed table, then random.
module tank_schedule_and_thermostat_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tstu_pkg::*;

    localparam int          PIPE_DEPTH   = 2;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HEAT_CUTOFF  = 150 * 16;
    localparam int          DAY_SECONDS  = 86400;
    localparam int          DAY_MINUTES  = 1440;
    localparam logic [2:0]  REG_SPARE    = 3'd7;
    localparam int          PHASES       = 12;
    localparam int          PHASE_TICKS  = 50;
    localparam int          LONG_HOLD    = 80;

    typedef struct packed {
        logic heater;
        logic light;
        logic feeder;
        logic air;
        logic backlight;
    } drive_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        tstu_item_t item;
        bit         checked;
        drive_t     want;
        logic [2:0] idx;
        logic [7:0] data;
    } row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [4:0]         s_clock_hour;
    logic [5:0]         s_clock_minute;
    logic [5:0]         s_clock_second;
    logic signed [15:0] s_water_temp;
    logic               s_sensor_present;
    logic               s_menu_active;
    logic               m_valid;
    logic               m_ready;
    logic               m_heater_on;
    logic               m_light_on;
    logic               m_feeder_on;
    logic               m_air_on;
    logic               m_backlight_on;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [7:0]         cfg_data;

    // Predictor copy of the configuration.
    logic [7:0]  setpt;
    logic [4:0]  light_from;
    logic [4:0]  light_to;
    logic [4:0]  feed_every;
    logic [7:0]  feed_len;
    logic [4:0]  air_every;
    logic [7:0]  air_len;

    // Predictor copy of the state.
    logic        heat_q;
    logic        lamp_q;
    logic        back_q;
    logic        feed_run;
    logic [16:0] feed_t0;
    logic [4:0]  feed_hr;
    logic        air_run;
    logic [10:0] air_t0;
    logic [4:0]  air_hr;

    drive_t drives_due[$];
    bit     tick_checked;
    drive_t tick_want;
    bit     gaps_on;
    int     rx_hold;
    int     fails;
    int     cycle_count;

    tank_schedule_and_thermostat_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_clock_hour     (s_clock_hour),
        .s_clock_minute   (s_clock_minute),
        .s_clock_second   (s_clock_second),
        .s_water_temp     (s_water_temp),
        .s_sensor_present (s_sensor_present),
        .s_menu_active    (s_menu_active),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_heater_on      (m_heater_on),
        .m_light_on       (m_light_on),
        .m_feeder_on      (m_feeder_on),
        .m_air_on         (m_air_on),
        .m_backlight_on   (m_backlight_on),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit run_due(logic [4:0] every, logic [4:0] hour, logic [4:0] last);
        int unsigned diff;
        diff = (int'(hour) + 48 - int'(last)) % 24;
        return every != 0 && diff >= every;
    endfunction

    function automatic drive_t tank_tick(tstu_item_t it);
        int          temp;
        int          sp16;
        int unsigned now;
        int unsigned elapsed;
        temp = $signed(it.water_temp);
        if (it.menu_active) begin
            back_q = 1'b1;
        end else begin
            sp16 = (setpt == SETPOINT_UNSET) ? int'(SETPOINT_DEFAULT) * 16 : int'(setpt) * 16;
            back_q = (it.clock_hour > BACKLIGHT_DAY_END || it.clock_hour < BACKLIGHT_DAY_START);
            if (it.sensor_present && temp < HEAT_CUTOFF) begin
                if (sp16 > temp) begin
                    heat_q = 1'b1;
                end else if (sp16 < temp) begin
                    heat_q = 1'b0;
                end
            end else begin
                heat_q = 1'b0;
            end
            if (light_from < light_to) begin
                lamp_q = (it.clock_hour >= light_from && it.clock_hour < light_to);
            end else if (light_from > light_to) begin
                lamp_q = (it.clock_hour >= light_from || it.clock_hour < light_to);
            end else begin
                lamp_q = 1'b0;
            end
            if (run_due(feed_every, it.clock_hour, feed_hr)) begin
                now = int'(it.clock_hour) * 3600 + int'(it.clock_minute) * 60
                    + int'(it.clock_second);
                if (!feed_run) begin
                    feed_run = 1'b1;
                    feed_t0  = now[16:0];
                end else begin
                    elapsed = (now + 2 * DAY_SECONDS - int'(feed_t0)) % DAY_SECONDS;
                    if (feed_len < elapsed) begin
                        feed_run = 1'b0;
                        feed_hr  = it.clock_hour;
                    end
                end
            end
            if (run_due(air_every, it.clock_hour, air_hr)) begin
                now = int'(it.clock_hour) * 60 + int'(it.clock_minute);
                if (!air_run) begin
                    air_run = 1'b1;
                    air_t0  = now[10:0];
                end else begin
                    elapsed = (now + 2 * DAY_MINUTES - int'(air_t0)) % DAY_MINUTES;
                    if (air_len < elapsed) begin
                        air_run = 1'b0;
                        air_hr  = it.clock_hour;
                    end
                end
            end
        end
        return '{heater: heat_q, light: lamp_q, feeder: feed_run, air: air_run,
                 backlight: back_q};
    endfunction

    function automatic row_t tick_row(int h, int m, int s, int t, bit sen, bit menu);
        row_t r;
        r.kind                = ROW_TICK;
        r.item.clock_hour     = h[4:0];
        r.item.clock_minute   = m[5:0];
        r.item.clock_second   = s[5:0];
        r.item.water_temp     = t[15:0];
        r.item.sensor_present = sen;
        r.item.menu_active    = menu;
        r.checked             = 1'b0;
        r.want                = '0;
        r.idx                 = '0;
        r.data                = '0;
        return r;
    endfunction

    function automatic row_t checked_row(int h, int m, int s, int t, bit sen, bit menu,
                                         drive_t want);
        row_t r;
        r         = tick_row(h, m, s, t, sen, menu);
        r.checked = 1'b1;
        r.want    = want;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [2:0] idx, logic [7:0] data);
        row_t r;
        r      = tick_row(0, 0, 0, 0, 1'b0, 1'b0);
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [7:0] hour_byte(int v);
        logic [2:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
        return {junk, v[4:0]};
    endfunction

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic send_tick(input tstu_item_t it, input bit checked, input drive_t want);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_clock_hour     = it.clock_hour;
        s_clock_minute   = it.clock_minute;
        s_clock_second   = it.clock_second;
        s_water_temp     = it.water_temp;
        s_sensor_present = it.sensor_present;
        s_menu_active    = it.menu_active;
        tick_checked     = checked;
        tick_want        = want;
        s_valid          = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (drives_due.size() != 0) @(negedge aclk);
        repeat (PIPE_DEPTH + 2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TEMP_SETPOINT:     setpt      = data;
            REG_LIGHT_ON_HOUR:     light_from = data[4:0];
            REG_LIGHT_OFF_HOUR:    light_to   = data[4:0];
            REG_FEED_CYCLE_HOURS:  feed_every = data[4:0];
            REG_FEED_DURATION_SEC: feed_len   = data;
            REG_AIR_CYCLE_HOURS:   air_every  = data[4:0];
            REG_AIR_DURATION_MIN:  air_len    = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [7:0] sp, input logic [7:0] lo, input logic [7:0] lf,
                             input logic [7:0] fc, input logic [7:0] fd,
                             input logic [7:0] ac, input logic [7:0] ad);
        drain();
        write_reg(REG_TEMP_SETPOINT, sp);
        write_reg(REG_LIGHT_ON_HOUR, lo);
        write_reg(REG_LIGHT_OFF_HOUR, lf);
        write_reg(REG_FEED_CYCLE_HOURS, fc);
        write_reg(REG_FEED_DURATION_SEC, fd);
        write_reg(REG_AIR_CYCLE_HOURS, ac);
        write_reg(REG_AIR_DURATION_MIN, ad);
    endtask

    always @(posedge aclk) begin : scoreboard
        drive_t got;
        drive_t want;
        drive_t pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_heater_on, m_light_on, m_feeder_on, m_air_on, m_backlight_on};
                if (drives_due.size() == 0) begin
                    note_fail($sformatf("result transaction with nothing expected: %b", got));
                end else begin
                    want = drives_due.pop_front();
                    if (got !== want) begin
                        note_fail($sformatf({"mismatch heater/light/feeder/air/backlight: ",
                                             "expected %b %b %b %b %b, got %b %b %b %b %b"},
                                            want.heater, want.light, want.feeder, want.air,
                                            want.backlight, got.heater, got.light,
                                            got.feeder, got.air, got.backlight));
                    end
                end
            end
            if (s_valid && s_ready) begin
                pred = tank_tick({s_clock_hour, s_clock_minute, s_clock_second, s_water_temp,
                                  s_sensor_present, s_menu_active});
                drives_due.push_back(tick_checked ? tick_want : pred);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (rx_hold != 0) begin
                m_ready = 1'b0;
                repeat (rx_hold) @(negedge aclk);
                rx_hold = 0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 5) : 0;
                if (stall != 0) begin
                    m_ready = 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        row_t        plan[$];
        tstu_item_t  it;
        logic [63:0] noise;
        logic [7:0]  sp;
        logic [7:0]  fc;
        logic [7:0]  fd;
        logic [7:0]  ac;
        logic [7:0]  ad;
        int          tod;
        int          step;
        int          tc;
        int          spv;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_clock_hour     = '0;
        s_clock_minute   = '0;
        s_clock_second   = '0;
        s_water_temp     = '0;
        s_sensor_present = 1'b0;
        s_menu_active    = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        tick_checked     = 1'b0;
        tick_want        = '0;
        gaps_on          = 1'b0;
        rx_hold          = 0;
        fails            = 0;
        cycle_count      = 0;

        setpt      = RST_TEMP_SETPOINT;
        light_from = RST_LIGHT_ON_HOUR;
        light_to   = RST_LIGHT_OFF_HOUR;
        feed_every = RST_FEED_CYCLE_HOURS;
        feed_len   = RST_FEED_DURATION_SEC;
        air_every  = RST_AIR_CYCLE_HOURS;
        air_len    = RST_AIR_DURATION_MIN;
        heat_q     = 1'b1;
        lamp_q     = 1'b1;
        back_q     = 1'b1;
        feed_run   = 1'b0;
        feed_t0    = '0;
        feed_hr    = '0;
        air_run    = 1'b0;
        air_t0     = '0;
        air_hr     = '0;

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Fields: hour, minute, second, temperature, sensor, menu.
        // Expected drives are ordered heater, light, feeder, air, backlight.
        plan.push_back(checked_row(0, 0, 0, 0, 1'b0, 1'b1, 5'b11001));
        plan.push_back(checked_row(12, 30, 0, 0, 1'b0, 1'b0, 5'b01000));
        plan.push_back(checked_row(0, 0, 0, -32768, 1'b1, 1'b0, 5'b10001));
        plan.push_back(checked_row(23, 59, 59, 32767, 1'b1, 1'b0, 5'b00001));
        plan.push_back(tick_row(12, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(7, 59, 59, 399, 1'b1, 1'b0));
        plan.push_back(tick_row(8, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(18, 0, 0, 401, 1'b1, 1'b0));
        plan.push_back(tick_row(20, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_TEMP_SETPOINT, 8'd254));
        plan.push_back(tick_row(12, 0, 0, 2399, 1'b1, 1'b0));
        plan.push_back(checked_row(12, 0, 0, 2400, 1'b1, 1'b0, 5'b01000));
        plan.push_back(cfg_row(REG_TEMP_SETPOINT, 8'd255));
        plan.push_back(tick_row(12, 0, 0, 399, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_TEMP_SETPOINT, 8'd0));
        plan.push_back(tick_row(12, 0, 0, -1, 1'b1, 1'b0));
        plan.push_back(tick_row(12, 0, 0, 1, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_LIGHT_ON_HOUR, 8'd22));
        plan.push_back(cfg_row(REG_LIGHT_OFF_HOUR, 8'd6));
        plan.push_back(tick_row(23, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(6, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_LIGHT_OFF_HOUR, 8'd22));
        plan.push_back(tick_row(22, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_FEED_CYCLE_HOURS, 8'd1));
        plan.push_back(cfg_row(REG_FEED_DURATION_SEC, 8'd3));
        plan.push_back(tick_row(1, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(1, 0, 5, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(1, 0, 6, 400, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_AIR_CYCLE_HOURS, 8'd2));
        plan.push_back(cfg_row(REG_AIR_DURATION_MIN, 8'd0));
        plan.push_back(cfg_row(REG_FEED_DURATION_SEC, 8'd20));
        plan.push_back(tick_row(3, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(3, 1, 0, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(23, 59, 50, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(0, 0, 5, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(0, 0, 15, 400, 1'b1, 1'b0));
        plan.push_back(cfg_row(REG_FEED_CYCLE_HOURS, 8'd24));
        plan.push_back(cfg_row(REG_SPARE, 8'hFF));
        plan.push_back(tick_row(12, 0, 0, 400, 1'b1, 1'b0));
        plan.push_back(tick_row(31, 63, 63, 400, 1'b1, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_tick(plan[i].item, plan[i].checked, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(8'd254, 8'd23, 8'd0, 8'd23, 8'd255, 8'd23, 8'd255);
                1: configure(8'd0, 8'd0, 8'd23, 8'd1, 8'd0, 8'd1, 8'd0);
                default: begin
                    case ($urandom_range(0, 5))
                        0:       sp = 8'd0;
                        1:       sp = 8'd254;
                        2:       sp = 8'd255;
                        default: sp = 8'($urandom_range(15, 35));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       fc = 8'd0;
                        1:       fc = hour_byte($urandom_range(24, 31));
                        default: fc = hour_byte($urandom_range(1, 3));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       ac = 8'd0;
                        1:       ac = hour_byte($urandom_range(24, 31));
                        default: ac = hour_byte($urandom_range(1, 3));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       fd = 8'd255;
                        1:       fd = 8'd0;
                        default: fd = 8'($urandom_range(1, 20));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       ad = 8'd255;
                        1:       ad = 8'd0;
                        default: ad = 8'($urandom_range(1, 60));
                    endcase
                    configure(sp, hour_byte($urandom_range(0, 23)),
                              hour_byte($urandom_range(0, 23)), fc, fd, ac, ad);
                end
            endcase

            if (p == 5) begin
                gaps_on = 1'b0;
                rx_hold = LONG_HOLD;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end

            tod = $urandom_range(0, DAY_SECONDS - 1);
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if ($urandom_range(0, 9) < 2) begin
                    noise = {$urandom(), $urandom()};
                    it    = noise[34:0];
                end else begin
                    case ($urandom_range(0, 3))
                        0:       step = $urandom_range(1, 4);
                        1:       step = $urandom_range(5, 120);
                        2:       step = $urandom_range(120, 1800);
                        default: step = $urandom_range(1800, 7200);
                    endcase
                    tod = (tod + step) % DAY_SECONDS;
                    spv = (setpt == SETPOINT_UNSET) ? int'(SETPOINT_DEFAULT) : int'(setpt);
                    if ($urandom_range(0, 9) == 0) begin
                        tc = 2390 + int'($urandom_range(0, 20));
                    end else begin
                        tc = spv * 16 + int'($urandom_range(0, 80)) - 40;
                    end
                    it.clock_hour     = 5'(tod / 3600);
                    it.clock_minute   = 6'((tod / 60) % 60);
                    it.clock_second   = 6'(tod % 60);
                    it.water_temp     = tc[15:0];
                    it.sensor_present = ($urandom_range(0, 15) != 0);
                    it.menu_active    = ($urandom_range(0, 11) == 0);
                end
                send_tick(it, 1'b0, '0);
            end
        end

        drain();
        if (drives_due.size() != 0) begin
            note_fail($sformatf("%0d expected results never arrived", drives_due.size()));
        end
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
